// ----- design/integer_to_ascii_formatter_unit_assert.svh -----
// assertion macros shared by the formatter modules
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define IAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset only
`define IAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/iaf_pkg.sv -----
package iaf_pkg;

    localparam int MAG_W         = 64;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int STORE_DEPTH   = 64;
    localparam int STORE_AW      = 6;
    localparam int MAX_DIGITS    = 22;
    localparam int MAX_CHARS     = 64;
    localparam int RESULT_LIMIT  = 64;
    localparam int CAP_LIMIT_I   = (MAX_CHARS < RESULT_LIMIT) ? MAX_CHARS : RESULT_LIMIT;
    localparam logic [6:0] CAP_LIMIT = 7'(CAP_LIMIT_I);

    // binary to bcd conversion, shift steps per cycle
    localparam int DABBLE_STEPS  = 8;
    localparam int DABBLE_CYCLES = MAG_W / DABBLE_STEPS;

    localparam logic [2:0] RADIX_OCT  = 3'd0;
    localparam logic [2:0] RADIX_UDEC = 3'd1;
    localparam logic [2:0] RADIX_SDEC = 3'd2;
    localparam logic [2:0] RADIX_HEXL = 3'd3;
    localparam logic [2:0] RADIX_HEXU = 3'd4;

    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_ALT   = 3;
    localparam int FLAG_ZERO  = 4;
    localparam int FLAG_NEG   = 5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef struct packed {
        logic load;
        logic dabble;
        logic extract;
        logic size;
        logic place;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic dec_in;
        logic extract_done;
        logic n_zero;
        logic emit_last;
    } t_stat;

    // one double-dabble step: correct each bcd digit, then shift left
    function automatic logic [BCD_W+MAG_W-1:0] dabble_shift(
        input logic [BCD_W+MAG_W-1:0] v
    );
        logic [BCD_W-1:0] bcd;
        bcd = v[BCD_W+MAG_W-1:MAG_W];
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                bcd[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {bcd[BCD_W-2:0], v[MAG_W-1:0], 1'b0};
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] res;
        if (d < 4'd10) begin
            res = CH_ZERO + {4'd0, d};
        end else begin
            res = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
        end
        return res;
    endfunction

endpackage

// ----- design/iaf_datapath.sv -----
`include "integer_to_ascii_formatter_unit_assert.svh"

module iaf_datapath import iaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic [63:0] i_magnitude,
    input  logic [2:0]  i_radix,
    input  logic [5:0]  i_format_flags,
    input  logic [5:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    input  logic [6:0]  i_room_left,
    output logic        o_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    logic [BCD_W-1:0]    r_work;
    logic [MAG_W-1:0]    r_bin;
    logic [STORE_AW-1:0] r_ndig;
    logic [5:0]          r_pos;
    logic                r_is_oct, r_is_hex, r_is_sdec, r_upper;
    logic [5:0]          r_flags, r_width, r_mind;
    logic [6:0]          r_room;
    logic [5:0]          r_dig_len;
    logic [1:0]          r_pre_len;
    logic [7:0]          r_pre0, r_pre1;
    logic [6:0]          r_len;
    logic [6:0]          r_n;
    logic [5:0]          r_pre_start;
    logic [6:0]          r_pre_end;
    logic [6:0]          r_dig_start;
    logic [6:0]          r_dig_top;
    logic [3:0]          r_store [STORE_DEPTH];
    logic [3:0]          r_rd_digit;
    logic                r_a_valid, r_a_last, r_a_dig, r_a_zero;
    logic [7:0]          r_a_char;

    logic                    dec_in;
    logic [BCD_W+MAG_W-1:0]  dabble_c;
    logic [BCD_W-1:0]        shifted_c;
    logic [3:0]              digit_c;
    logic                    left, zero_pad;
    logic [5:0]              dig_len_c;
    logic [1:0]              pre_len_c;
    logic [7:0]              pre0_c, pre1_c;
    logic [6:0]              width7, total_c, pad_full, cap_c, n_c;
    logic [5:0]              pad_c, pre_start_c;
    logic [6:0]              pos7, pre_k;
    logic                    in_pre, in_dig;
    logic [6:0]              idx_full;
    logic [STORE_AW-1:0]     idx_c;
    logic                    ext_zero;
    logic [7:0]              a_char_c;
    logic                    emit_last_c;

    assign dec_in = !(i_radix == RADIX_OCT || i_radix == RADIX_HEXL || i_radix == RADIX_HEXU);

    always_comb begin
        dabble_c = {r_work, r_bin};
        for (int s = 0; s < DABBLE_STEPS; s++) begin
            dabble_c = dabble_shift(dabble_c);
        end
    end

    assign shifted_c = r_is_oct ? (r_work >> 3) : (r_work >> 4);
    assign digit_c   = r_is_oct ? {1'b0, r_work[2:0]} : r_work[3:0];

    assign left     = r_flags[FLAG_LEFT];
    assign zero_pad = !left && r_flags[FLAG_ZERO];

    // sizing: digits and prefix
    always_comb begin
        dig_len_c = (r_ndig > r_mind) ? r_ndig : r_mind;
        pre_len_c = 2'd0;
        pre0_c    = CH_ZERO;
        pre1_c    = r_upper ? CH_X_UP : CH_X_LO;
        if (r_is_sdec) begin
            if (r_flags[FLAG_NEG]) begin
                pre_len_c = 2'd1;
                pre0_c    = CH_MINUS;
            end else if (r_flags[FLAG_PLUS]) begin
                pre_len_c = 2'd1;
                pre0_c    = CH_PLUS;
            end else if (r_flags[FLAG_SPACE]) begin
                pre_len_c = 2'd1;
                pre0_c    = CH_SPACE;
            end
        end else if (r_is_oct && r_flags[FLAG_ALT]) begin
            pre_len_c = 2'd1;
        end else if (r_is_hex && r_flags[FLAG_ALT]) begin
            pre_len_c = 2'd2;
        end
    end

    // placement: padding, run length and region bounds
    always_comb begin
        width7      = {1'b0, r_width};
        total_c     = (width7 > r_len) ? width7 : r_len;
        pad_full    = (width7 > r_len) ? (width7 - r_len) : 7'd0;
        pad_c       = pad_full[5:0];
        cap_c       = (r_room > CAP_LIMIT) ? CAP_LIMIT : r_room;
        n_c         = (total_c < cap_c) ? total_c : cap_c;
        pre_start_c = (!left && !zero_pad) ? pad_c : 6'd0;
    end

    // character selection for the position being issued
    always_comb begin
        pos7     = {1'b0, r_pos};
        in_pre   = (pos7 >= {1'b0, r_pre_start}) && (pos7 < r_pre_end);
        in_dig   = (pos7 >= r_dig_start) && (pos7 <= r_dig_top);
        pre_k    = pos7 - {1'b0, r_pre_start};
        idx_full = r_dig_top - pos7;
        idx_c    = idx_full[STORE_AW-1:0];
        // leading zeros asked for by min_digits were never stored
        ext_zero = idx_c >= r_ndig;
        if (in_pre) begin
            a_char_c = pre_k[0] ? r_pre1 : r_pre0;
        end else begin
            a_char_c = zero_pad ? CH_ZERO : CH_SPACE;
        end
        emit_last_c = (pos7 == r_n - 7'd1);
    end

    assign o_stat.dec_in       = dec_in;
    assign o_stat.extract_done = (shifted_c == '0);
    assign o_stat.n_zero       = (r_n == 7'd0);
    assign o_stat.emit_last    = emit_last_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig    <= '0;
            r_pos     <= '0;
            r_n       <= '0;
            r_a_valid <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_ndig <= '0;
                r_pos  <= '0;
            end
            if (i_ctrl.extract) begin
                r_ndig <= r_ndig + 1'b1;
            end
            if (i_ctrl.place) begin
                r_n <= n_c;
            end
            if (i_ctrl.emit) begin
                r_pos <= r_pos + 1'b1;
            end
            r_a_valid <= i_ctrl.emit;
            o_strobe  <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_work    <= dec_in ? '0 : {{(BCD_W-MAG_W){1'b0}}, i_magnitude};
            r_bin     <= i_magnitude;
            r_is_oct  <= (i_radix == RADIX_OCT);
            r_is_hex  <= (i_radix == RADIX_HEXL) || (i_radix == RADIX_HEXU);
            r_is_sdec <= (i_radix == RADIX_SDEC);
            r_upper   <= (i_radix == RADIX_HEXU);
            r_flags   <= i_format_flags;
            r_width   <= i_field_width;
            r_mind    <= i_min_digits;
            r_room    <= i_room_left;
        end else if (i_ctrl.dabble) begin
            r_work <= dabble_c[BCD_W+MAG_W-1:MAG_W];
            r_bin  <= dabble_c[MAG_W-1:0];
        end else if (i_ctrl.extract) begin
            r_work <= shifted_c;
        end
        if (i_ctrl.size) begin
            r_dig_len <= dig_len_c;
            r_pre_len <= pre_len_c;
            r_pre0    <= pre0_c;
            r_pre1    <= pre1_c;
            r_len     <= 7'(dig_len_c) + 7'(pre_len_c);
        end
        if (i_ctrl.place) begin
            r_pre_start <= pre_start_c;
            r_pre_end   <= 7'(pre_start_c) + 7'(r_pre_len);
            r_dig_start <= left ? 7'(r_pre_len) : 7'(r_pre_len) + 7'(pad_c);
            r_dig_top   <= (left ? r_len : total_c) - 7'd1;
        end
        r_a_last <= emit_last_c;
        r_a_dig  <= in_dig && !in_pre;
        r_a_zero <= ext_zero;
        r_a_char <= a_char_c;
        o_last_char <= r_a_last;
        if (r_a_dig) begin
            o_out_char <= r_a_zero ? CH_ZERO : digit_char(r_rd_digit, r_upper);
        end else begin
            o_out_char <= r_a_char;
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.extract) begin
            r_store[r_ndig] <= digit_c;
        end
        r_rd_digit <= r_store[idx_c];
    end

    `IAF_ASSERT_IMPL(a_digit_bound, i_clk, i_rst_n, 1'b1, r_ndig <= 6'(MAX_DIGITS), "digit count overrun")
    `IAF_ASSERT_IMPL(a_read_in_range, i_clk, i_rst_n, i_ctrl.emit && in_dig, idx_c < r_dig_len, "digit read outside run")
    `IAF_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last_char, !o_strobe, "beat after last character")

endmodule

// ----- design/iaf_ctrl.sv -----
`include "integer_to_ascii_formatter_unit_assert.svh"

module iaf_ctrl import iaf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DABBLE  = 3'd1;
    localparam logic [2:0] S_EXTRACT = 3'd2;
    localparam logic [2:0] S_SIZE    = 3'd3;
    localparam logic [2:0] S_PLACE   = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    localparam logic [2:0] CNT_LAST = 3'(DABBLE_CYCLES - 1);

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = i_stat.dec_in ? S_DABBLE : S_EXTRACT;
                end
            end
            S_DABBLE: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_EXTRACT;
                end
            end
            S_EXTRACT: begin
                if (i_stat.extract_done) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.n_zero || i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl.load    = (r_state == S_IDLE) && i_start;
        o_ctrl.dabble  = (r_state == S_DABBLE);
        o_ctrl.extract = (r_state == S_EXTRACT);
        o_ctrl.size    = (r_state == S_SIZE);
        o_ctrl.place   = (r_state == S_PLACE);
        o_ctrl.emit    = (r_state == S_EMIT) && !i_stat.n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `IAF_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy, "start not taken")
    `IAF_ASSERT_IMPL(a_dabble_count, i_clk, i_rst_n, r_state != S_DABBLE, r_cnt == 3'd0 || r_state == S_EXTRACT, "dabble count stray")

endmodule

// ----- design/integer_to_ascii_formatter_unit.sv -----
// Formats one integer per command, printf style, as a run of ASCII characters. A command is
// taken when start is high while busy is low; busy then stays high through binary to decimal
// conversion (decimal radices only), the extraction of each significant digit into the digit
// store, the sizing and placement states, and the issue of the characters. Each character
// appears on o_out_char for exactly one cycle with o_strobe high, the first one reaching the
// outputs through the r_a_valid and o_strobe registers after emission begins, so the tail of a
// run trails busy; o_last_char marks the final one. A run cut to zero room gives no beats at
// all. The receiver cannot stall: every beat must be taken in the cycle it is shown. Issue
// rate is one character per cycle, set by the single read port of the digit store.
module integer_to_ascii_formatter_unit import iaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_magnitude,
    input  logic [2:0]  i_radix,
    input  logic [5:0]  i_format_flags,
    input  logic [5:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    input  logic [6:0]  i_room_left,
    output logic        o_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    t_ctrl ctrl;
    t_stat stat;

    iaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    iaf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_magnitude    (i_magnitude),
        .i_radix        (i_radix),
        .i_format_flags (i_format_flags),
        .i_field_width  (i_field_width),
        .i_min_digits   (i_min_digits),
        .i_room_left    (i_room_left),
        .o_strobe       (o_strobe),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

endmodule
